// File: sv/tlb_page_table_translate_core_assert.svh
`ifndef TLB_PAGE_TABLE_TRANSLATE_CORE_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATE_CORE_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define TPT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define TPT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/tpt_pkg.sv
`default_nettype none

package tpt_pkg;

   localparam int PAGE_BITS    = 8;
   localparam int OFFSET_BITS  = 8;
   localparam int TLB_ENTRIES  = 16;
   localparam int VA_BITS      = 16;
   localparam int PA_BITS      = 16;
   localparam int NUM_PAGES    = 1 << PAGE_BITS;
   localparam int TLB_IDX_BITS = $clog2(TLB_ENTRIES);
   localparam int COUNT_BITS   = PAGE_BITS + 1;
   localparam int HIT_BITS     = 32;

   typedef logic [PAGE_BITS-1:0]    page_type;
   typedef logic [PAGE_BITS-1:0]    frame_type;
   typedef logic [OFFSET_BITS-1:0]  offset_type;
   typedef logic [TLB_IDX_BITS-1:0] tlb_idx_type;
   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [HIT_BITS-1:0]     hit_count_type;

   typedef struct packed {
      logic      hit;
      frame_type frame;
   } tlb_look_type;

   typedef struct packed {
      logic      en;
      page_type  page;
      frame_type frame;
   } tlb_fill_type;

endpackage

`default_nettype wire

// File: sv/tpt_map_ram.sv
`default_nettype none

module tpt_map_ram (
   input  wire              clock,
   input  wire              rd_en,
   input  tpt_pkg::page_type  rd_page,
   input  wire              wr_en,
   input  tpt_pkg::page_type  wr_page,
   input  tpt_pkg::frame_type wr_frame,
   output tpt_pkg::frame_type rd_frame
);
   import tpt_pkg::*;

   frame_type mem [NUM_PAGES];
   frame_type rdata_ff;
   frame_type fwd_data_ff;
   logic      fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_page] <= wr_frame;
      end
      if (rd_en) begin
         rdata_ff    <= mem[rd_page];
         fwd_ff      <= wr_en && (wr_page == rd_page);
         fwd_data_ff <= wr_frame;
      end
   end

   // write in the same cycle as the read of that entry: return the new frame
   assign rd_frame = fwd_ff ? fwd_data_ff : rdata_ff;

endmodule

`default_nettype wire

// File: sv/tpt_tlb.sv
`default_nettype none

module tpt_tlb (
   input  wire                   clock,
   input  wire                   reset,
   input  tpt_pkg::page_type     look_page,
   output tpt_pkg::tlb_look_type look,
   input  tpt_pkg::tlb_fill_type fill
);
   import tpt_pkg::*;

   page_type                tag_ff   [TLB_ENTRIES];
   frame_type               frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0]  valid_ff;
   tlb_idx_type             victim_ff;
   tlb_idx_type             victim_in;

   always_comb begin
      look.hit   = 1'b0;
      look.frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == look_page)) begin
            look.hit   = 1'b1;
            look.frame = frame_ff[i];
         end
      end
   end

   always_comb begin
      victim_in = victim_ff;
      if (fill.en) begin
         if (victim_ff == tlb_idx_type'(TLB_ENTRIES - 1)) begin
            victim_in = '0;
         end else begin
            victim_in = victim_ff + tlb_idx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         victim_ff <= '0;
      end else begin
         victim_ff <= victim_in;
         if (fill.en) begin
            valid_ff[victim_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fill.en) begin
         tag_ff[victim_ff]   <= fill.page;
         frame_ff[victim_ff] <= fill.frame;
      end
   end

endmodule

`default_nettype wire

// File: sv/tlb_page_table_translate_core.sv
// TLB and page-table address translation with demand paging.
// Input channel req_: one virtual address per item; the high byte is the page,
// the low byte the offset. Result channel rsp_: one item per input item, in
// order, with the physical address, TLB hit and page fault flags, the fault
// count and the saturating TLB hit count, both including this item.
// Pipeline: the page-table memory is read in the cycle the item is accepted;
// the lookup stage then matches all TLB entries in parallel, resolves the frame,
// and on advance updates TLB, page table and counters and loads the output register.
// Throughput: one item per cycle while the result is not stalled; the read of the
// page-table memory is registered, with a bypass for a fault that writes the entry
// being read.
// Reset: TLB and page table come up empty, FIFO pointer, free-frame pointer
// and counters at zero; no memory clearing pass is needed.
// Stall: while rsp_ready is low the result holds; one more item may sit in
// the lookup stage, after which req_ready drops.
`default_nettype none

module tlb_page_table_translate_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire [tpt_pkg::VA_BITS-1:0]    req_virtual_address,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [tpt_pkg::PA_BITS-1:0]   rsp_physical_address,
   output logic                          rsp_tlb_hit,
   output logic                          rsp_page_fault,
   output logic [tpt_pkg::COUNT_BITS-1:0] rsp_fault_total,
   output logic [tpt_pkg::HIT_BITS-1:0]  rsp_hit_total
);
   import tpt_pkg::*;

   logic                    accept;
   logic                    advance;
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [VA_BITS-1:0]      s1_va_ff;
   page_type                req_page;
   page_type                s1_page;
   offset_type              s1_offset;
   logic [NUM_PAGES-1:0]    map_valid_ff;
   frame_type               ram_frame;
   tlb_look_type            look;
   tlb_fill_type            fill;
   logic                    fault;
   frame_type               frame;
   count_type               fault_cnt_ff;
   count_type               fault_cnt_in;
   count_type               free_ff;
   count_type               free_in;
   hit_count_type           hit_cnt_ff;
   hit_count_type           hit_cnt_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [PA_BITS-1:0]      rsp_pa_ff;
   logic                    rsp_hit_ff;
   logic                    rsp_fault_ff;
   count_type               rsp_fault_total_ff;
   hit_count_type           rsp_hit_total_ff;

   assign req_page  = req_virtual_address[OFFSET_BITS +: PAGE_BITS];
   assign s1_page   = s1_va_ff[OFFSET_BITS +: PAGE_BITS];
   assign s1_offset = s1_va_ff[OFFSET_BITS-1:0];

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   tpt_map_ram u_map_ram (
      .clock    (clock),
      .rd_en    (accept),
      .rd_page  (req_page),
      .wr_en    (fill.en),
      .wr_page  (fill.page),
      .wr_frame (fill.frame),
      .rd_frame (ram_frame)
   );

   tpt_tlb u_tlb (
      .clock     (clock),
      .reset     (reset),
      .look_page (s1_page),
      .look      (look),
      .fill      (fill)
   );

   always_comb begin
      fault = !look.hit && !map_valid_ff[s1_page];
      if (look.hit) begin
         frame = look.frame;
      end else if (map_valid_ff[s1_page]) begin
         frame = ram_frame;
      end else begin
         frame = free_ff[PAGE_BITS-1:0];
      end
      fill.en    = advance && fault;
      fill.page  = s1_page;
      fill.frame = frame;
   end

   always_comb begin
      fault_cnt_in = fault_cnt_ff;
      free_in      = free_ff;
      hit_cnt_in   = hit_cnt_ff;
      if (advance && fault) begin
         fault_cnt_in = fault_cnt_ff + count_type'(1);
         free_in      = free_ff + count_type'(1);
      end
      if (advance && look.hit && (hit_cnt_ff != '1)) begin
         hit_cnt_in = hit_cnt_ff + hit_count_type'(1);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_valid_ff <= '0;
         fault_cnt_ff <= '0;
         free_ff      <= '0;
         hit_cnt_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fault_cnt_ff <= fault_cnt_in;
         free_ff      <= free_in;
         hit_cnt_ff   <= hit_cnt_in;
         if (fill.en) begin
            map_valid_ff[s1_page] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_va_ff <= req_virtual_address;
      end
      if (advance) begin
         rsp_pa_ff          <= PA_BITS'({frame, s1_offset});
         rsp_hit_ff         <= look.hit;
         rsp_fault_ff       <= fault;
         rsp_fault_total_ff <= fault_cnt_in;
         rsp_hit_total_ff   <= hit_cnt_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_fault_total      = rsp_fault_total_ff;
   assign rsp_hit_total        = rsp_hit_total_ff;

endmodule

`default_nettype wire

// File: sv/tpt_checker.sv
`default_nettype none

`include "tlb_page_table_translate_core_assert.svh"

module tpt_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [tpt_pkg::PA_BITS-1:0]     rsp_physical_address,
   input wire                            rsp_tlb_hit,
   input wire                            rsp_page_fault,
   input wire [tpt_pkg::COUNT_BITS-1:0]  rsp_fault_total,
   input wire [tpt_pkg::HIT_BITS-1:0]    rsp_hit_total
);

   `TPT_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "result valid right after reset")

   `TPT_ASSERT(a_hold_on_stall, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_physical_address) && $stable(rsp_hit_total), "result changed while stalled")

   `TPT_ASSERT(a_hit_xor_fault, rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault), "TLB hit and page fault in one item")

   `TPT_ASSERT(a_counts_cover_flags, rsp_valid |-> (!rsp_page_fault || rsp_fault_total != 0) && (!rsp_tlb_hit || rsp_hit_total != 0), "running count misses this item")

endmodule

bind tlb_page_table_translate_core tpt_checker u_tpt_checker (.*);

`default_nettype wire

// File: test/tlb_page_table_translate_core_checker.sv
module tlb_page_table_translate_core_checker
   import tpt_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  wire [VA_BITS-1:0]     req_virtual_address,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  wire [PA_BITS-1:0]     rsp_physical_address,
   input  wire                   rsp_tlb_hit,
   input  wire                   rsp_page_fault,
   input  wire [COUNT_BITS-1:0]  rsp_fault_total,
   input  wire [HIT_BITS-1:0]    rsp_hit_total,
   output int                    mismatches,
   output int                    pending,
   output int                    tlb_hits,
   output int                    table_hits,
   output int                    faults
);

   typedef struct packed {
      logic [PA_BITS-1:0] phys;
      logic               hit;
      logic               fault;
      count_type          fault_total;
      hit_count_type      hit_total;
   } translation_type;

   page_type               tlb_tag   [TLB_ENTRIES];
   frame_type              tlb_frame [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid;
   frame_type              map_frame [NUM_PAGES];
   logic [NUM_PAGES-1:0]   map_valid;
   tlb_idx_type            victim;
   count_type              free_frame;
   count_type              fault_cnt;
   hit_count_type          hit_cnt;

   translation_type        xlate_q[$];

   task automatic clear_state();
      int i;
      for (i = 0; i < TLB_ENTRIES; i++) begin
         tlb_tag[i]   = '0;
         tlb_frame[i] = '0;
      end
      tlb_valid  = '0;
      map_valid  = '0;
      victim     = '0;
      free_frame = '0;
      fault_cnt  = '0;
      hit_cnt    = '0;
      xlate_q.delete();
      mismatches = 0;
      tlb_hits   = 0;
      table_hits = 0;
      faults     = 0;
   endtask

   function automatic translation_type translate(input logic [VA_BITS-1:0] va);
      translation_type r;
      page_type     page;
      offset_type   offset;
      frame_type    frame;
      logic         found;
      int           i;
      page   = va[OFFSET_BITS +: PAGE_BITS];
      offset = va[OFFSET_BITS-1:0];
      frame  = '0;
      found  = 1'b0;
      r      = '0;
      for (i = 0; i < TLB_ENTRIES; i++) begin
         if (!found && tlb_valid[i] && tlb_tag[i] == page) begin
            frame = tlb_frame[i];
            found = 1'b1;
         end
      end
      if (found) begin
         if (hit_cnt != '1)
            hit_cnt = hit_cnt + 1'b1;
      end else if (map_valid[page]) begin
         frame = map_frame[page];
      end else begin
         r.fault           = 1'b1;
         frame             = free_frame[PAGE_BITS-1:0];
         map_frame[page]   = frame;
         map_valid[page]   = 1'b1;
         tlb_tag[victim]   = page;
         tlb_frame[victim] = frame;
         tlb_valid[victim] = 1'b1;
         victim            = victim + 1'b1;
         free_frame        = free_frame + 1'b1;
         fault_cnt         = fault_cnt + 1'b1;
      end
      r.phys        = PA_BITS'({frame, offset});
      r.hit         = found;
      r.fault_total = fault_cnt;
      r.hit_total   = hit_cnt;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (xlate_q.size() == 0) begin
               $error("result item with no translation pending");
               mismatches++;
            end else begin
               want = xlate_q.pop_front();
               check_field("physical_address", 32'(want.phys),
                           32'(rsp_physical_address));
               check_field("tlb_hit", 32'(want.hit), 32'(rsp_tlb_hit));
               check_field("page_fault", 32'(want.fault), 32'(rsp_page_fault));
               check_field("fault_total", 32'(want.fault_total), 32'(rsp_fault_total));
               check_field("hit_total", 32'(want.hit_total), 32'(rsp_hit_total));
            end
         end
         if (req_valid && req_ready) begin
            want = translate(req_virtual_address);
            xlate_q.push_back(want);
            if (want.hit)
               tlb_hits++;
            else if (want.fault)
               faults++;
            else
               table_hits++;
         end
      end
      pending <= xlate_q.size();
   end

endmodule

// File: test/tlb_page_table_translate_core_tb.sv
module tlb_page_table_translate_core_tb;
   import tpt_pkg::*;

   localparam int RANDOM_ITEMS = 1130;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 120;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VA_BITS-1:0]     req_virtual_address;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [PA_BITS-1:0]     rsp_physical_address;
   logic                   rsp_tlb_hit;
   logic                   rsp_page_fault;
   logic [COUNT_BITS-1:0]  rsp_fault_total;
   logic [HIT_BITS-1:0]    rsp_hit_total;

   int mismatches, pending, tlb_hits, table_hits, faults;

   logic [NUM_PAGES-1:0] touched;
   page_type             recent_fill [TLB_ENTRIES];
   int                   fill_ix;
   int                   sent;
   int                   idle_cycles;

   tlb_page_table_translate_core dut (.*);
   tlb_page_table_translate_core_checker chk (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("tlb_page_table_translate_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic [VA_BITS-1:0] va);
      int gap;
      page_type pg;
      pg = va[OFFSET_BITS +: PAGE_BITS];
      if (!touched[pg]) begin
         touched[pg]          = 1'b1;
         recent_fill[fill_ix] = pg;
         fill_ix              = (fill_ix + 1) % TLB_ENTRIES;
      end
      gap = ((sent >= 100 && sent < 160) || (sent >= 600 && sent < 650)) ?
            0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // receiver: random stalls, quiet windows, one long hold-off
   initial begin
      int gap;
      int got;
      got = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      gap = $urandom_range(0, 12);
      forever begin
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got++;
         if (got == 350)
            gap = LONG_HOLD;
         else if ((got >= 100 && got < 180) || (got >= 620 && got < 700))
            gap = 0;
         else
            gap = $urandom_range(0, 12);
      end
   end

   initial begin
      int mode;
      int i;
      page_type pg;
      page_type sweep;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_virtual_address <= '0;
      touched  = '0;
      fill_ix  = 0;
      sent     = 0;
      sweep    = '0;
      for (i = 0; i < TLB_ENTRIES; i++)
         recent_fill[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, TLB hits, then enough new pages to push the first two out
      send_item(16'h0000);
      send_item(16'hFFFF);
      send_item(16'h00FF);
      send_item(16'hFF00);
      for (i = 1; i <= 16; i++)
         send_item({page_type'(i), offset_type'($urandom_range(0, 255))});
      // evicted from the TLB but still mapped in the page table
      send_item(16'h0012);
      send_item(16'hFF34);
      drain();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 4) begin
            pg = recent_fill[$urandom_range(0, TLB_ENTRIES - 1)];
         end else if (mode < 7) begin
            pg = page_type'($urandom_range(0, NUM_PAGES - 1));
         end else begin
            pg    = sweep;
            sweep = sweep + 1'b1;
         end
         send_item({pg, offset_type'($urandom_range(0, 255))});
         if (i == 800)
            drain();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      $display("translated %0d addresses: %0d TLB hits, %0d page-table hits, %0d faults",
               tlb_hits + table_hits + faults, tlb_hits, table_hits, faults);
      $display("all %0d pages mapped: %0d", NUM_PAGES, touched == '1);
      if (mismatches == 0) begin
         $display("tlb_page_table_translate_core test passed");
      end else begin
         $display("tlb_page_table_translate_core test failed");
      end
      $finish;
   end

endmodule

// File: tlb_page_table_translate_core.f
+incdir+sv
sv/tpt_pkg.sv
sv/tpt_map_ram.sv
sv/tpt_tlb.sv
sv/tlb_page_table_translate_core.sv
sv/tpt_checker.sv
test/tlb_page_table_translate_core_checker.sv
test/tlb_page_table_translate_core_tb.sv
